// ===== design/linear_blend_vertex_skinning_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the vertex skinning unit
// Clocked on clk and disabled in reset; the user module provides both.
// ----------------------------------------------------------------------------
`ifndef LINEAR_BLEND_VERTEX_SKINNING_UNIT_ASSERT_SVH
`define LINEAR_BLEND_VERTEX_SKINNING_UNIT_ASSERT_SVH

// same-cycle implication
`define LBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbs assertion failed");

// next-cycle implication
`define LBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbs assertion failed");

`endif

// ===== design/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, constants and helpers of the vertex skinning unit.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int MAX_BONES      = 256;
  localparam int INFLUENCES     = 4;
  localparam int WORDS_PER_BONE = 12;
  localparam int PAL_DEPTH      = MAX_BONES * WORDS_PER_BONE;
  localparam int PAL_AW         = $clog2(PAL_DEPTH);
  localparam int DIV_STEPS      = 48;

  localparam logic [1:0]  SLOT_LAST  = 2'(INFLUENCES - 1);
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  typedef enum logic [2:0] {
    CMD_LOAD_SKIN   = 3'd0,
    CMD_LOAD_NORMAL = 3'd1,
    CMD_POSITION    = 3'd2,
    CMD_NORMAL      = 3'd3,
    CMD_TANGENT     = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_BLEND,
    C_NORM,
    C_PUSH
  } core_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SCALE,
    N_SQUARE,
    N_ROOT,
    N_DIVIDE,
    N_DONE
  } norm_state_t;

  typedef struct packed {
    logic [2:0][31:0] vec;
    logic [3:0][7:0]  bone;
    logic [3:0][16:0] weight;
    logic             trans;
  } blend_req_t;

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== design/lbs_if.sv =====
// ----------------------------------------------------------------------------
// lbs_in_if / lbs_out_if
// Valid/ready channels of the vertex skinning unit.
// ----------------------------------------------------------------------------
interface lbs_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic [7:0]         bone_a;
  logic [7:0]         bone_b;
  logic [7:0]         bone_c;
  logic [7:0]         bone_d;
  logic [16:0]        weight_a;
  logic [16:0]        weight_b;
  logic [16:0]        weight_c;
  logic [16:0]        weight_d;

  modport source (output valid, command, vec_x, vec_y, vec_z, bone_a, bone_b, bone_c,
                  bone_d, weight_a, weight_b, weight_c, weight_d, input ready);
  modport sink (input valid, command, vec_x, vec_y, vec_z, bone_a, bone_b, bone_c,
                bone_d, weight_a, weight_b, weight_c, weight_d, output ready);
endinterface

interface lbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               degenerate;

  modport source (output valid, out_x, out_y, out_z, degenerate, input ready);
  modport sink (input valid, out_x, out_y, out_z, degenerate, output ready);
endinterface

// ===== design/lbs_ram.sv =====
// ----------------------------------------------------------------------------
// lbs_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 3072,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lbs_blend.sv =====
// ----------------------------------------------------------------------------
// lbs_blend
// Walks the bone words of one palette, one read per cycle, and accumulates
// the weighted transformed vector through a four-stage pipeline.
// ----------------------------------------------------------------------------
module lbs_blend (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  lbs_pkg::blend_req_t         req,
  output logic [lbs_pkg::PAL_AW-1:0]  raddr,
  input  logic [31:0]                 rdata,
  output logic                        done,
  output logic [2:0][31:0]            result
);

  logic        issuing;
  logic        running;
  logic [1:0]  slot;
  logic [1:0]  col;
  logic [1:0]  row;
  logic [7:0]  cur_bone;
  logic [16:0] cur_w_raw;
  logic [16:0] cur_w;
  logic        active;
  logic [1:0]  last_row;
  logic [3:0]  word;
  logic        issue_v;

  logic        s1_v, s2_v, s3_v, s4_v;
  logic [1:0]  s1_row, s1_col, s2_col, s3_col, s4_col;
  logic        s1_last, s2_last, s2_first;
  logic [16:0] s1_w, s2_w, s3_w;
  logic signed [47:0] s2_term;
  logic signed [49:0] tsum_r;
  logic signed [31:0] s3_t;
  logic signed [31:0] s4_p;
  logic signed [33:0] acc [3];

  logic signed [31:0] vsel;
  logic signed [63:0] mul;
  logic signed [47:0] wext;
  logic signed [47:0] term;
  logic signed [49:0] term_ext;
  logic signed [49:0] tsum;
  logic signed [49:0] prodw;
  logic signed [33:0] p_ext;

  assign cur_bone  = req.bone[slot];
  assign cur_w_raw = req.weight[slot];
  assign cur_w     = (cur_w_raw > lbs_pkg::WEIGHT_ONE) ? lbs_pkg::WEIGHT_ONE : cur_w_raw;
  assign active    = (cur_w_raw != 17'd0) && (int'(cur_bone) < lbs_pkg::MAX_BONES);
  assign last_row  = req.trans ? 2'd3 : 2'd2;
  assign word      = {1'b0, row, 1'b0} + {2'b00, row} + {2'b00, col};
  assign raddr     = lbs_pkg::PAL_AW'({cur_bone, 3'b000}) + lbs_pkg::PAL_AW'({cur_bone, 2'b00})
                   + lbs_pkg::PAL_AW'(word);
  assign issue_v   = issuing && active;

  always_comb begin
    unique case (s1_row)
      2'd0:    vsel = req.vec[0];
      2'd1:    vsel = req.vec[1];
      default: vsel = req.vec[2];
    endcase
  end

  assign mul      = vsel * $signed(rdata);
  assign wext     = $signed(rdata);
  assign term     = (s1_row == 2'd3) ? wext : mul[63:16];
  assign term_ext = s2_term;
  assign tsum     = (s2_first ? 50'sd0 : tsum_r) + term_ext;
  assign prodw    = s3_t * $signed({1'b0, s3_w});
  assign p_ext    = s4_p;

  assign done = running && !start && !issuing && !s1_v && !s2_v && !s3_v && !s4_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      issuing <= 1'b0;
      running <= 1'b0;
      s1_v    <= 1'b0;
      s2_v    <= 1'b0;
      s3_v    <= 1'b0;
      s4_v    <= 1'b0;
      slot    <= 2'd0;
      col     <= 2'd0;
      row     <= 2'd0;
    end else begin
      if (start) begin
        issuing <= 1'b1;
        running <= 1'b1;
        slot    <= 2'd0;
        col     <= 2'd0;
        row     <= 2'd0;
      end else begin
        if (done) begin
          running <= 1'b0;
        end
        if (issuing) begin
          if (active && row != last_row) begin
            row <= row + 2'd1;
          end else if (active && col != 2'd2) begin
            row <= 2'd0;
            col <= col + 2'd1;
          end else begin
            row <= 2'd0;
            col <= 2'd0;
            if (slot == lbs_pkg::SLOT_LAST) begin
              issuing <= 1'b0;
            end else begin
              slot <= slot + 2'd1;
            end
          end
        end
      end
      s1_v <= issue_v;
      s2_v <= s1_v;
      s3_v <= s2_v && s2_last;
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_row   <= row;
    s1_col   <= col;
    s1_last  <= (row == last_row);
    s1_w     <= cur_w;
    s2_term  <= term;
    s2_first <= (s1_row == 2'd0);
    s2_last  <= s1_last;
    s2_col   <= s1_col;
    s2_w     <= s1_w;
    if (s2_v) begin
      tsum_r <= tsum;
    end
    s3_t   <= lbs_pkg::sat32(tsum);
    s3_col <= s2_col;
    s3_w   <= s2_w;
    s4_p   <= prodw[47:16];
    s4_col <= s3_col;
    if (start) begin
      acc[0] <= 34'sd0;
      acc[1] <= 34'sd0;
      acc[2] <= 34'sd0;
    end else if (s4_v) begin
      acc[s4_col] <= acc[s4_col] + p_ext;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      result[c] = lbs_pkg::sat32(50'(acc[c]));
    end
  end

endmodule

// ===== design/lbs_norm.sv =====
// ----------------------------------------------------------------------------
// lbs_norm
// Iterative normalizer: prescale, sum of squares, bit-pair square root,
// then restoring division of each component, one bit per cycle.
// ----------------------------------------------------------------------------
module lbs_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [2:0][31:0] vin,
  output logic             done,
  output logic [2:0][31:0] vout,
  output logic             degen
);

  lbs_pkg::norm_state_t state, state_next;

  logic [31:0] mag [3];
  logic [2:0]  neg;
  logic [31:0] mx;
  logic [63:0] sq;
  logic [63:0] n;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [31:0] len;
  logic [31:0] rem;
  logic [47:0] dvd;
  logic [1:0]  idx;
  logic [5:0]  cnt;

  logic [31:0] mag_in [3];
  logic [31:0] mx_in;
  logic [63:0] sq_next;
  logic [63:0] rb;
  logic        root_ge;
  logic [63:0] res_nx;
  logic [32:0] remt;
  logic        div_ge;
  logic [47:0] quo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vin[i][31] ? (32'd0 - vin[i]) : vin[i];
    end
    mx_in = mag_in[0];
    if (mag_in[1] > mx_in) mx_in = mag_in[1];
    if (mag_in[2] > mx_in) mx_in = mag_in[2];
  end

  assign sq_next = sq + mag[idx] * mag[idx];
  assign rb      = res + bitv;
  assign root_ge = (n >= rb);
  assign res_nx  = root_ge ? ((res >> 1) + bitv) : (res >> 1);
  assign remt    = {rem, dvd[47]};
  assign div_ge  = (remt >= {1'b0, len});
  assign quo     = {dvd[46:0], div_ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbs_pkg::N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      lbs_pkg::N_IDLE: begin
        if (start) begin
          state_next = (mx_in == 32'd0) ? lbs_pkg::N_DONE : lbs_pkg::N_SCALE;
        end
      end
      lbs_pkg::N_SCALE: begin
        if (mx[31:30] != 2'b00) state_next = lbs_pkg::N_SQUARE;
      end
      lbs_pkg::N_SQUARE: begin
        if (idx == 2'd2) state_next = lbs_pkg::N_ROOT;
      end
      lbs_pkg::N_ROOT: begin
        if (bitv == 64'd1) state_next = lbs_pkg::N_DIVIDE;
      end
      lbs_pkg::N_DIVIDE: begin
        if (cnt == 6'(lbs_pkg::DIV_STEPS - 1) && idx == 2'd2) state_next = lbs_pkg::N_DONE;
      end
      lbs_pkg::N_DONE: begin
        done       = 1'b1;
        state_next = lbs_pkg::N_IDLE;
      end
      default: state_next = lbs_pkg::N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      lbs_pkg::N_IDLE: begin
        if (start) begin
          for (int i = 0; i < 3; i++) begin
            mag[i]  <= mag_in[i];
            neg[i]  <= vin[i][31];
            vout[i] <= 32'd0;
          end
          mx    <= mx_in;
          degen <= (mx_in == 32'd0);
          sq    <= 64'd0;
          idx   <= 2'd0;
        end
      end
      lbs_pkg::N_SCALE: begin
        if (mx[31:30] == 2'b00) begin
          mx <= mx << 1;
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] << 1;
          end
        end
      end
      lbs_pkg::N_SQUARE: begin
        sq  <= sq_next;
        idx <= idx + 2'd1;
        if (idx == 2'd2) begin
          n    <= sq_next;
          res  <= 64'd0;
          bitv <= 64'h4000_0000_0000_0000;
        end
      end
      lbs_pkg::N_ROOT: begin
        if (root_ge) n <= n - rb;
        res  <= res_nx;
        bitv <= bitv >> 2;
        if (bitv == 64'd1) begin
          len <= (res_nx == 64'd0) ? 32'd1 : res_nx[31:0];
          idx <= 2'd0;
          rem <= 32'd0;
          dvd <= {mag[0], 16'h0000};
          cnt <= 6'd0;
        end
      end
      lbs_pkg::N_DIVIDE: begin
        rem <= div_ge ? 32'(remt - {1'b0, len}) : remt[31:0];
        dvd <= quo;
        cnt <= cnt + 6'd1;
        if (cnt == 6'(lbs_pkg::DIV_STEPS - 1)) begin
          vout[idx] <= neg[idx] ? (32'd0 - quo[31:0]) : quo[31:0];
          idx       <= idx + 2'd1;
          rem       <= 32'd0;
          dvd       <= {mag[idx + 2'd1], 16'h0000};
          cnt       <= 6'd0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== design/linear_blend_vertex_skinning_unit.sv =====
// A load is written in the cycle it is accepted. A position item is offered
// once the blend has read every word of each weighted bone and passed over
// each skipped slot; a normal or tangent item reads only the rotation words of
// each weighted bone, then passes the normalizer (bit-serial root and divider).
// One skin item is in flight at a time; the output register frees the core.
// Reset clears control only; palette words are undefined until loaded.
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_unit
// Four-bone linear blend skinning over two bone palette RAMs, Q16.16.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_unit (
  input logic       clk,
  input logic       rst,
  lbs_in_if.sink    req,
  lbs_out_if.source rsp
);

  lbs_pkg::core_state_t state, state_next;
  lbs_pkg::blend_req_t  req_q;
  lbs_pkg::cmd_t        cmd;

  logic use_normal;
  logic accept;
  logic is_skin_cmd;
  logic load_ok;
  logic we_skin, we_normal;
  logic blend_go, norm_go, push;
  logic blend_done, norm_done, norm_degen;
  logic [lbs_pkg::PAL_AW-1:0] waddr, raddr;
  logic [31:0] skin_rdata, normal_rdata, rdata;
  logic [2:0][31:0] blend_res, norm_res;

  assign cmd    = lbs_pkg::cmd_t'(req.command);
  assign accept = req.valid && req.ready;

  always_comb begin
    is_skin_cmd = 1'b0;
    we_skin     = 1'b0;
    we_normal   = 1'b0;
    load_ok     = (int'(req.bone_a) < lbs_pkg::MAX_BONES)
               && (int'(req.bone_b) < lbs_pkg::WORDS_PER_BONE);
    unique case (cmd)
      lbs_pkg::CMD_LOAD_SKIN:   we_skin   = accept && load_ok;
      lbs_pkg::CMD_LOAD_NORMAL: we_normal = accept && load_ok;
      lbs_pkg::CMD_POSITION,
      lbs_pkg::CMD_NORMAL,
      lbs_pkg::CMD_TANGENT:     is_skin_cmd = 1'b1;
      default: begin
      end
    endcase
  end

  assign waddr = lbs_pkg::PAL_AW'({req.bone_a, 3'b000}) + lbs_pkg::PAL_AW'({req.bone_a, 2'b00})
               + lbs_pkg::PAL_AW'(req.bone_b[3:0]);

  lbs_ram #(.WIDTH(32), .DEPTH(lbs_pkg::PAL_DEPTH)) u_skin_ram (
    .clk(clk), .we(we_skin), .waddr(waddr), .wdata(req.vec_x),
    .raddr(raddr), .rdata(skin_rdata)
  );

  lbs_ram #(.WIDTH(32), .DEPTH(lbs_pkg::PAL_DEPTH)) u_normal_ram (
    .clk(clk), .we(we_normal), .waddr(waddr), .wdata(req.vec_x),
    .raddr(raddr), .rdata(normal_rdata)
  );

  assign rdata = use_normal ? normal_rdata : skin_rdata;

  lbs_blend u_blend (
    .clk(clk), .rst(rst), .start(blend_go), .req(req_q),
    .raddr(raddr), .rdata(rdata), .done(blend_done), .result(blend_res)
  );

  lbs_norm u_norm (
    .clk(clk), .rst(rst), .start(norm_go), .vin(blend_res),
    .done(norm_done), .vout(norm_res), .degen(norm_degen)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lbs_pkg::C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    blend_go   = 1'b0;
    norm_go    = 1'b0;
    push       = 1'b0;
    unique case (state)
      lbs_pkg::C_IDLE: begin
        req.ready = 1'b1;
        if (accept && is_skin_cmd) begin
          blend_go   = 1'b1;
          state_next = lbs_pkg::C_BLEND;
        end
      end
      lbs_pkg::C_BLEND: begin
        if (blend_done) begin
          if (req_q.trans) begin
            state_next = lbs_pkg::C_PUSH;
          end else begin
            norm_go    = 1'b1;
            state_next = lbs_pkg::C_NORM;
          end
        end
      end
      lbs_pkg::C_NORM: begin
        if (norm_done) state_next = lbs_pkg::C_PUSH;
      end
      lbs_pkg::C_PUSH: begin
        if (!rsp.valid || rsp.ready) begin
          push       = 1'b1;
          state_next = lbs_pkg::C_IDLE;
        end
      end
      default: state_next = lbs_pkg::C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (blend_go) begin
      req_q.vec    <= {req.vec_z, req.vec_y, req.vec_x};
      req_q.bone   <= {req.bone_d, req.bone_c, req.bone_b, req.bone_a};
      req_q.weight <= {req.weight_d, req.weight_c, req.weight_b, req.weight_a};
      req_q.trans  <= (cmd == lbs_pkg::CMD_POSITION);
      use_normal   <= (cmd == lbs_pkg::CMD_NORMAL);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (push) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (req_q.trans) begin
        rsp.out_x      <= blend_res[0];
        rsp.out_y      <= blend_res[1];
        rsp.out_z      <= blend_res[2];
        rsp.degenerate <= 1'b0;
      end else begin
        rsp.out_x      <= norm_res[0];
        rsp.out_y      <= norm_res[1];
        rsp.out_z      <= norm_res[2];
        rsp.degenerate <= norm_degen;
      end
    end
  end

endmodule

// ===== design/lbs_checker.sv =====
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks of the vertex skinning unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_blend_vertex_skinning_unit_assert.svh"

module lbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        out_degenerate
);

  logic        out_stall;
  logic        out_zero;
  logic        in_load;
  logic        in_skin;
  logic [96:0] out_bus;

  assign out_stall = out_valid && !out_ready;
  assign out_bus   = {out_degenerate, out_z, out_y, out_x};
  assign out_zero  = (out_x == 32'd0) && (out_y == 32'd0) && (out_z == 32'd0);
  assign in_load   = in_valid && in_ready
                  && (in_command == lbs_pkg::CMD_LOAD_SKIN
                   || in_command == lbs_pkg::CMD_LOAD_NORMAL);
  assign in_skin   = in_valid && in_ready
                  && (in_command == lbs_pkg::CMD_POSITION
                   || in_command == lbs_pkg::CMD_NORMAL
                   || in_command == lbs_pkg::CMD_TANGENT);

  `LBS_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_bus))
  `LBS_ASSERT_IMP(a_degen_zero, out_valid && out_degenerate, out_zero)
  `LBS_ASSERT_NXT(a_load_ready, in_load, in_ready)
  `LBS_ASSERT_NXT(a_skin_busy, in_skin, !in_ready)

endmodule

bind linear_blend_vertex_skinning_unit lbs_checker u_lbs_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(req.valid),
  .in_ready(req.ready),
  .in_command(req.command),
  .out_valid(rsp.valid),
  .out_ready(rsp.ready),
  .out_x(rsp.out_x),
  .out_y(rsp.out_y),
  .out_z(rsp.out_z),
  .out_degenerate(rsp.degenerate)
);

// ===== tb/sv/linear_blend_vertex_skinning_unit_tb.sv =====
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_unit_tb
// Drives load, position, normal, tangent and reserved-command items with random
// idling and one long output hold-off. Each skin result is checked field by field
// against an in-bench Q16.16 skinning predictor. Only fully loaded bones are weighted.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_unit_tb;

  localparam int          ITEM_TARGET    = 1650;
  localparam int          CYCLE_LIMIT    = 3000000;
  localparam int          DRAIN_CYCLES   = 400;
  localparam logic [2:0]  CMD_RESERVED_LO = 3'd5;

  typedef struct {
    logic [2:0]       cmd;
    logic [2:0][31:0] vec;
    logic [3:0][7:0]  bone;
    logic [3:0][16:0] wt;
  } vertex_item_t;

  typedef struct {
    logic [2:0][31:0] v;
    logic             degen;
  } skinned_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lbs_in_if  req_if ();
  lbs_out_if rsp_if ();

  linear_blend_vertex_skinning_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  always #5 clk = ~clk;

  vertex_item_t pending_items[$];
  skinned_t     expected_out[$];

  logic [31:0] skin_words[lbs_pkg::PAL_DEPTH];
  logic [31:0] normal_words[lbs_pkg::PAL_DEPTH];
  logic [11:0] skin_loaded[lbs_pkg::MAX_BONES];
  logic [11:0] normal_loaded[lbs_pkg::MAX_BONES];

  int errors       = 0;
  int cycles       = 0;
  int issued       = 0;
  int accepted     = 0;
  int received     = 0;
  int hold_left    = 0;
  bit hold_done    = 0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s at result %0d: got %h want %h", what, received, got, want);
    errors++;
  endtask

  function automatic logic [31:0] rand_word();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) return 32'($urandom_range(0, 262143)) - 32'd131072;
    if (sel < 70) return $urandom();
    if (sel < 80) return 32'd0;
    if (sel < 90) return ($urandom_range(0, 1) != 0) ? 32'h00010000 : 32'hffff0000;
    return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
  endfunction

  function automatic logic [31:0] rand_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) return 32'($urandom_range(0, 32'h7ffffff)) - 32'h4000000;
    if (sel < 90) return $urandom();
    if (sel < 95) return 32'd0;
    return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
  endfunction

  function automatic vertex_item_t load_item(input logic [2:0] cmd, input int bone,
                                             input int word, input logic [31:0] val);
    vertex_item_t it;
    it.cmd = cmd;
    it.vec = {$urandom(), $urandom(), val};
    it.bone = {8'($urandom()), 8'($urandom()), 8'(word), 8'(bone)};
    it.wt = {17'($urandom()), 17'($urandom()), 17'($urandom()), 17'($urandom())};
    if (cmd == lbs_pkg::CMD_LOAD_SKIN && word < lbs_pkg::WORDS_PER_BONE) begin
      skin_loaded[bone][word] = 1'b1;
    end
    if (cmd == lbs_pkg::CMD_LOAD_NORMAL && word < lbs_pkg::WORDS_PER_BONE) begin
      normal_loaded[bone][word] = 1'b1;
    end
    return it;
  endfunction

  task automatic load_bone(input logic [2:0] cmd, input int bone, input bit ident);
    int order[12];
    int j, k, t;
    for (j = 0; j < 12; j++) order[j] = j;
    for (j = 11; j > 0; j--) begin
      k = $urandom_range(0, j);
      t = order[j]; order[j] = order[k]; order[k] = t;
    end
    for (j = 0; j < 12; j++) begin
      pending_items.push_back(load_item(cmd, bone, order[j],
        ident ? ((order[j] % 4 == 0 && order[j] < 9) ? 32'h00010000 : 32'd0) : rand_word()));
    end
  endtask

  function automatic bit bone_ready(input logic [2:0] cmd, input int bone);
    if (cmd == lbs_pkg::CMD_NORMAL) return normal_loaded[bone] == 12'hfff;
    return skin_loaded[bone] == 12'hfff;
  endfunction

  function automatic int pick_loaded(input logic [2:0] cmd);
    int b;
    do b = $urandom_range(0, lbs_pkg::MAX_BONES - 1); while (!bone_ready(cmd, b));
    return b;
  endfunction

  function automatic vertex_item_t skin_item(input logic [2:0] cmd);
    vertex_item_t it;
    int i, sel;
    it.cmd = cmd;
    for (i = 0; i < 3; i++) it.vec[i] = rand_coord();
    for (i = 0; i < 4; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
        it.wt[i] = 17'd0;
        it.bone[i] = 8'($urandom());
      end else begin
        it.bone[i] = 8'(pick_loaded(cmd));
        if (sel < 75) it.wt[i] = 17'($urandom_range(1, 32768));
        else if (sel < 88) it.wt[i] = lbs_pkg::WEIGHT_ONE;
        else it.wt[i] = 17'($urandom_range(65537, 131071));
      end
    end
    return it;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic skinned_t blend_vertex(input vertex_item_t it);
    skinned_t  r;
    longint    acc[3];
    longint    t, w, vr, m;
    bit [63:0] mag[3];
    bit [63:0] mx, sq, n, root, b, q;
    int        i, c, k, s, base;
    bit        trans;
    trans = (it.cmd == lbs_pkg::CMD_POSITION);
    for (c = 0; c < 3; c++) acc[c] = 0;
    for (i = 0; i < lbs_pkg::INFLUENCES; i++) begin
      w = (it.wt[i] > lbs_pkg::WEIGHT_ONE) ? 65536 : longint'(it.wt[i]);
      if (w == 0) continue;
      base = int'(it.bone[i]) * lbs_pkg::WORDS_PER_BONE;
      for (c = 0; c < 3; c++) begin
        t = 0;
        for (k = 0; k < 3; k++) begin
          vr = longint'(signed'(it.vec[k]));
          m = longint'(signed'(it.cmd == lbs_pkg::CMD_NORMAL ? normal_words[base + k*3 + c]
                                                              : skin_words[base + k*3 + c]));
          t += (vr * m) >>> 16;
        end
        if (trans) t += longint'(signed'(skin_words[base + 9 + c]));
        t = longint'(signed'(clamp32(t)));
        acc[c] += (t * w) >>> 16;
      end
    end
    for (c = 0; c < 3; c++) acc[c] = longint'(signed'(clamp32(acc[c])));
    r.degen = 1'b0;
    if (!trans) begin
      mx = 0;
      for (c = 0; c < 3; c++) begin
        mag[c] = acc[c] < 0 ? -acc[c] : acc[c];
        if (mag[c] > mx) mx = mag[c];
      end
      if (mx == 0) begin
        r.degen = 1'b1;
      end else begin
        s = 0;
        while ((mx << 1) < (64'd1 << 31)) begin
          mx <<= 1;
          s++;
        end
        sq = 0;
        for (c = 0; c < 3; c++) begin
          mag[c] <<= s;
          sq += mag[c] * mag[c];
        end
        n = sq; root = 0; b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
          if (n >= root + b) begin
            n -= root + b;
            root = (root >> 1) + b;
          end else begin
            root >>= 1;
          end
          b >>= 2;
        end
        if (root == 0) root = 1;
        for (c = 0; c < 3; c++) begin
          q = (mag[c] << 16) / root;
          acc[c] = longint'(signed'(clamp32(acc[c] < 0 ? -longint'(q) : longint'(q))));
        end
      end
    end
    for (c = 0; c < 3; c++) r.v[c] = acc[c][31:0];
    return r;
  endfunction

  function automatic void take_item(input vertex_item_t it);
    int idx;
    idx = int'(it.bone[0]) * lbs_pkg::WORDS_PER_BONE + int'(it.bone[1]);
    if (it.cmd == lbs_pkg::CMD_LOAD_SKIN || it.cmd == lbs_pkg::CMD_LOAD_NORMAL) begin
      if (it.bone[1] < lbs_pkg::WORDS_PER_BONE) begin
        if (it.cmd == lbs_pkg::CMD_LOAD_SKIN) skin_words[idx] = it.vec[0];
        else normal_words[idx] = it.vec[0];
      end
    end else if (it.cmd <= lbs_pkg::CMD_TANGENT) begin
      expected_out.push_back(blend_vertex(it));
    end
  endfunction

  // stimulus
  initial begin
    vertex_item_t it;
    int bones_pre[8];
    int i, sel;
    bones_pre = '{0, 1, 2, 3, 127, 128, 254, 255};
    req_if.valid = 1'b0;
    req_if.command = lbs_pkg::CMD_LOAD_SKIN;
    req_if.vec_x = '0; req_if.vec_y = '0; req_if.vec_z = '0;
    req_if.bone_a = '0; req_if.bone_b = '0; req_if.bone_c = '0; req_if.bone_d = '0;
    req_if.weight_a = '0; req_if.weight_b = '0; req_if.weight_c = '0; req_if.weight_d = '0;
    rsp_if.ready = 1'b0;
    for (i = 0; i < lbs_pkg::MAX_BONES; i++) begin
      skin_loaded[i] = '0;
      normal_loaded[i] = '0;
    end
    for (i = 0; i < lbs_pkg::PAL_DEPTH; i++) begin
      skin_words[i] = '0;
      normal_words[i] = '0;
    end

    load_bone(lbs_pkg::CMD_LOAD_SKIN, 0, 1);
    load_bone(lbs_pkg::CMD_LOAD_NORMAL, 0, 1);
    for (i = 1; i < 8; i++) begin
      load_bone(lbs_pkg::CMD_LOAD_SKIN, bones_pre[i], 0);
      load_bone(lbs_pkg::CMD_LOAD_NORMAL, bones_pre[i], 0);
    end

    // directed: identity, extremes, zero vectors, weights, ignored items
    it = skin_item(lbs_pkg::CMD_POSITION);
    it.vec = {32'h00030000, 32'hfffe0000, 32'h00018000};
    it.bone = '0; it.wt = {17'd0, 17'd0, 17'd0, lbs_pkg::WEIGHT_ONE};
    pending_items.push_back(it);
    it.cmd = lbs_pkg::CMD_NORMAL; pending_items.push_back(it);
    it.cmd = lbs_pkg::CMD_TANGENT; pending_items.push_back(it);
    it.vec = '0; pending_items.push_back(it);
    it.cmd = lbs_pkg::CMD_NORMAL; pending_items.push_back(it);
    it.cmd = lbs_pkg::CMD_POSITION; pending_items.push_back(it);
    it = skin_item(lbs_pkg::CMD_TANGENT); it.wt = '0; pending_items.push_back(it);
    it.cmd = lbs_pkg::CMD_POSITION; pending_items.push_back(it);
    for (i = 0; i < 3; i++) begin
      it = skin_item(lbs_pkg::CMD_POSITION + 3'(i));
      it.vec = {32'h7fffffff, 32'h80000000, 32'h7fffffff};
      it.bone = {8'd255, 8'd254, 8'd128, 8'd127};
      it.wt = {17'h1ffff, lbs_pkg::WEIGHT_ONE, 17'd1, 17'h10001};
      pending_items.push_back(it);
    end
    it = skin_item(lbs_pkg::CMD_NORMAL);
    it.vec = {32'h80000000, 32'h80000000, 32'h80000000};
    pending_items.push_back(it);
    pending_items.push_back(load_item(lbs_pkg::CMD_LOAD_SKIN, 3, 12, $urandom()));
    pending_items.push_back(load_item(lbs_pkg::CMD_LOAD_NORMAL, 255, 255, $urandom()));
    for (i = 0; i < 3; i++) begin
      it = skin_item(lbs_pkg::CMD_TANGENT);
      it.cmd = CMD_RESERVED_LO + 3'(i);
      pending_items.push_back(it);
    end

    while (pending_items.size() < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 6) begin
        load_bone($urandom_range(0, 1) ? lbs_pkg::CMD_LOAD_NORMAL : lbs_pkg::CMD_LOAD_SKIN,
                  $urandom_range(0, lbs_pkg::MAX_BONES - 1), 0);
      end else if (sel < 12) begin
        pending_items.push_back(load_item(
          $urandom_range(0, 1) ? lbs_pkg::CMD_LOAD_NORMAL : lbs_pkg::CMD_LOAD_SKIN,
          $urandom_range(0, lbs_pkg::MAX_BONES - 1),
          ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 11),
          rand_word()));
      end else if (sel < 16) begin
        it = skin_item(lbs_pkg::CMD_POSITION);
        it.cmd = CMD_RESERVED_LO + 3'($urandom_range(0, 2));
        pending_items.push_back(it);
      end else begin
        pending_items.push_back(skin_item(lbs_pkg::CMD_POSITION + 3'($urandom_range(0, 2))));
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_items.size() != 0 || req_if.valid || accepted != issued
           || expected_out.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_out.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // driver
  always @(negedge clk) begin
    vertex_item_t it;
    bit quiet;
    if (!rst && (!req_if.valid || accepted == issued)) begin
      quiet = (issued > 700 && issued < 1000);
      if (pending_items.size() == 0 || (!quiet && $urandom_range(0, 99) < 26)) begin
        req_if.valid <= 1'b0;
      end else begin
        it = pending_items.pop_front();
        req_if.valid <= 1'b1;
        req_if.command <= it.cmd;
        req_if.vec_x <= it.vec[0];
        req_if.vec_y <= it.vec[1];
        req_if.vec_z <= it.vec[2];
        req_if.bone_a <= it.bone[0];
        req_if.bone_b <= it.bone[1];
        req_if.bone_c <= it.bone[2];
        req_if.bone_d <= it.bone[3];
        req_if.weight_a <= it.wt[0];
        req_if.weight_b <= it.wt[1];
        req_if.weight_c <= it.wt[2];
        req_if.weight_d <= it.wt[3];
        issued++;
      end
    end
  end

  // receiver readiness, with one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (!hold_done && received == 300) begin
        hold_done <= 1;
        hold_left <= 3000;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (received > 650 && received < 900) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= 26);
      end
    end
  end

  // input capture and result check
  always @(posedge clk) begin
    vertex_item_t it;
    skinned_t     want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else if (!rst) begin
      if (req_if.valid && req_if.ready) begin
        it.cmd = req_if.command;
        it.vec = {req_if.vec_z, req_if.vec_y, req_if.vec_x};
        it.bone = {req_if.bone_d, req_if.bone_c, req_if.bone_b, req_if.bone_a};
        it.wt = {req_if.weight_d, req_if.weight_c, req_if.weight_b, req_if.weight_a};
        take_item(it);
        accepted++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_out.size() == 0) begin
          report("unexpected result", rsp_if.out_x, 32'd0);
        end else begin
          want = expected_out.pop_front();
          if (rsp_if.out_x !== want.v[0]) report("out_x", rsp_if.out_x, want.v[0]);
          if (rsp_if.out_y !== want.v[1]) report("out_y", rsp_if.out_y, want.v[1]);
          if (rsp_if.out_z !== want.v[2]) report("out_z", rsp_if.out_z, want.v[2]);
          if (rsp_if.degenerate !== want.degen) begin
            report("degenerate", 32'(rsp_if.degenerate), 32'(want.degen));
          end
        end
        received++;
      end
    end
  end

endmodule
